@@ design/pte_pkg.sv @@
// ----------------------------------------------------------------------------
// pte_pkg
// Shared types and constants for the prefix tree engine.
// ----------------------------------------------------------------------------
package pte_pkg;

	localparam int NODE_POOL    = 1024;
	localparam int BRANCHES     = 26;
	localparam int MAX_WORD_LEN = 32;

	localparam int NODE_W  = (NODE_POOL > 1) ? $clog2(NODE_POOL) : 1;
	localparam int NF_W    = $clog2(NODE_POOL + 1);
	localparam int CT_DEPTH = NODE_POOL * BRANCHES;
	localparam int CT_AW   = $clog2(CT_DEPTH);
	localparam int LEN_W   = $clog2(MAX_WORD_LEN + 2);
	localparam int BUF_AW  = (MAX_WORD_LEN > 1) ? $clog2(MAX_WORD_LEN) : 1;
	localparam int LTR_W   = 5;
	localparam int CNT_W   = 16;

	localparam logic [7:0] LETTER_LO = 8'h61;
	localparam logic [7:0] LETTER_HI = 8'h7a;
	localparam logic [CNT_W-1:0] COUNT_MAX = '1;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_IGNORED = 2'd1;
	localparam logic [1:0] ST_FULL    = 2'd2;
	localparam logic [1:0] ST_LONG    = 2'd3;

	typedef struct packed {
		logic       action;
		logic [7:0] char_code;
		logic       no_char;
		logic       last;
	} item_t;

	typedef struct packed {
		logic [CNT_W-1:0] word_count;
		logic             prefix_found;
		logic [1:0]       status;
	} result_t;

	// child table access
	typedef struct packed {
		logic              we;
		logic [CT_AW-1:0]  addr;
		logic [NODE_W-1:0] wdata;
	} ct_req_t;

	// node count table access
	typedef struct packed {
		logic              we;
		logic [NODE_W-1:0] addr;
		logic [CNT_W-1:0]  wdata;
	} cn_req_t;

endpackage

@@ design/pte_tables.sv @@
// ----------------------------------------------------------------------------
// pte_tables
// Child table and node count memories, with the clearing pass after reset.
// ----------------------------------------------------------------------------
module pte_tables (
	input  logic                    clk,
	input  logic                    arst_n,
	input  pte_pkg::ct_req_t        ct_req,
	output logic [pte_pkg::NODE_W-1:0] ct_rdata,
	input  pte_pkg::cn_req_t        cn_req,
	output logic [pte_pkg::CNT_W-1:0]  cn_rdata,
	output logic                    clearing
);
	import pte_pkg::*;

	logic [NODE_W-1:0] ct_mem [CT_DEPTH];
	logic [CNT_W-1:0]  cn_mem [NODE_POOL];

	logic [CT_AW-1:0] clr_addr_q;
	logic             clearing_q;

	// clearing sweep, one child entry a cycle (and one count while the address is within the count table)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
			clearing_q <= 1'b1;
		end else if (clearing_q) begin
			if (clr_addr_q == CT_AW'(CT_DEPTH - 1)) begin
				clearing_q <= 1'b0;
			end
			clr_addr_q <= clr_addr_q + 1'b1;
		end
	end

	assign clearing = clearing_q;

	// child table port
	always_ff @(posedge clk) begin
		if (clearing_q) begin
			ct_mem[clr_addr_q] <= '0;
		end else if (ct_req.we) begin
			ct_mem[ct_req.addr] <= ct_req.wdata;
		end
		ct_rdata <= ct_mem[ct_req.addr];
	end

	// count table port
	always_ff @(posedge clk) begin
		if (clearing_q) begin
			if (clr_addr_q < CT_AW'(NODE_POOL)) begin
				cn_mem[clr_addr_q[NODE_W-1:0]] <= '0;
			end
		end else if (cn_req.we) begin
			cn_mem[cn_req.addr] <= cn_req.wdata;
		end
		cn_rdata <= cn_mem[cn_req.addr];
	end

endmodule

@@ design/prefix_trie_engine.sv @@
// ----------------------------------------------------------------------------
// prefix_trie_engine
// Prefix tree over lowercase words, one character per transaction.
// ----------------------------------------------------------------------------
// Channel | Ports                 | Handshake
// input   | start, busy, item     | taken when start high and busy low
// result  | done, result          | done strobes one cycle, no back-pressure
//
// A character that walks the tree takes a child table read, then the walk step
// in S_WALK. A character off the tree, an invalid one or none needs S_IDLE only.
// The closing transaction runs S_FIN, S_CISS, S_CRD for a query on the tree;
// an insert adds one S_ALLOC step per new node (node allocation writes the
// child table one entry a cycle); a query miss or rejected insert ends in S_FIN.
// After reset a clearing pass of NODE_POOL*BRANCHES entries (26624) keeps busy high.
// The result sits in an output register; done goes high as busy falls.
module prefix_trie_engine (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  pte_pkg::item_t   item,
	output logic             done,
	output pte_pkg::result_t result
);
	import pte_pkg::*;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_WALK  = 3'd1;
	localparam logic [2:0] S_FIN   = 3'd2;
	localparam logic [2:0] S_ALLOC = 3'd3;
	localparam logic [2:0] S_CISS  = 3'd4;
	localparam logic [2:0] S_CRD   = 3'd5;

	logic [2:0]        state_q;
	logic [NODE_W-1:0] cur_q;
	logic [LEN_W-1:0]  len_q;
	logic [LEN_W-1:0]  depth_q;
	logic [NF_W-1:0]   nf_q;
	logic              bad_q;
	logic              miss_q;
	logic              act_q;
	logic              last_q;
	logic              done_q;
	result_t           result_q;
	logic [LTR_W-1:0]  wbuf_q [MAX_WORD_LEN];

	ct_req_t           ct_req;
	cn_req_t           cn_req;
	logic [NODE_W-1:0] ct_rdata;
	logic [CNT_W-1:0]  cn_rdata;
	logic              clearing;

	logic              accept;
	logic              chr_ok;
	logic [LTR_W-1:0]  letter;
	logic [LTR_W-1:0]  buf_ltr;
	logic [LEN_W-1:0]  needed;
	logic [NF_W:0]     room;

	pte_tables u_tables (
		.clk      (clk),
		.arst_n   (arst_n),
		.ct_req   (ct_req),
		.ct_rdata (ct_rdata),
		.cn_req   (cn_req),
		.cn_rdata (cn_rdata),
		.clearing (clearing)
	);

	assign busy   = clearing || (state_q != S_IDLE);
	assign accept = start && !busy;
	assign done   = done_q;
	assign result = result_q;

	// character decode
	assign chr_ok  = (item.char_code >= LETTER_LO) && (item.char_code <= LETTER_HI);
	assign letter  = LTR_W'(item.char_code - LETTER_LO);
	assign buf_ltr = wbuf_q[depth_q[BUF_AW-1:0]];
	assign needed  = len_q - depth_q;
	assign room    = (NF_W+1)'(NODE_POOL) - {1'b0, nf_q};

	// memory requests
	always_comb begin
		ct_req.we    = 1'b0;
		ct_req.wdata = NODE_W'(nf_q);
		ct_req.addr  = CT_AW'(cur_q) * CT_AW'(BRANCHES) + CT_AW'(letter);
		if (state_q == S_ALLOC) begin
			ct_req.we   = 1'b1;
			ct_req.addr = CT_AW'(cur_q) * CT_AW'(BRANCHES) + CT_AW'(buf_ltr);
		end
		cn_req.addr  = cur_q;
		cn_req.we    = (state_q == S_CRD) && !act_q;
		cn_req.wdata = (cn_rdata == COUNT_MAX) ? cn_rdata : cn_rdata + 1'b1;
	end

	// word buffer
	always_ff @(posedge clk) begin
		if (accept && !item.no_char && chr_ok && (len_q < LEN_W'(MAX_WORD_LEN))) begin
			wbuf_q[len_q[BUF_AW-1:0]] <= letter;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			cur_q    <= '0;
			len_q    <= '0;
			depth_q  <= '0;
			nf_q     <= NF_W'(1);
			bad_q    <= 1'b0;
			miss_q   <= 1'b0;
			act_q    <= 1'b0;
			last_q   <= 1'b0;
			done_q   <= 1'b0;
			result_q <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						act_q  <= item.action;
						last_q <= item.last;
						if (item.last) begin
							state_q <= S_FIN;
						end
						if (!item.no_char) begin
							if (len_q <= LEN_W'(MAX_WORD_LEN)) begin
								len_q <= len_q + 1'b1;
							end
							if (!chr_ok) begin
								bad_q  <= 1'b1;
								miss_q <= 1'b1;
							end else if (!miss_q) begin
								state_q <= S_WALK;
							end
						end
					end
				end
				S_WALK: begin
					if (ct_rdata == '0) begin
						miss_q <= 1'b1;
					end else begin
						cur_q <= ct_rdata;
						if (depth_q <= LEN_W'(MAX_WORD_LEN)) begin
							depth_q <= depth_q + 1'b1;
						end
					end
					state_q <= last_q ? S_FIN : S_IDLE;
				end
				S_FIN: begin
					result_q <= '0;
					if (act_q) begin
						if (miss_q) begin
							done_q  <= 1'b1;
							state_q <= S_IDLE;
						end else begin
							state_q <= S_CISS;
						end
					end else if ((len_q == '0) || bad_q) begin
						result_q.status <= ST_IGNORED;
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else if (len_q > LEN_W'(MAX_WORD_LEN)) begin
						result_q.status <= ST_LONG;
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else if ((nf_q > NF_W'(NODE_POOL)) ||
						((NF_W+1)'(needed) > room)) begin
						result_q.status <= ST_FULL;
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else if (needed == '0) begin
						state_q <= S_CISS;
					end else begin
						state_q <= S_ALLOC;
					end
					if (done_q == 1'b0 && (state_q == S_FIN)) begin
						// per-word state returns to rest only once the result is out
					end
				end
				S_ALLOC: begin
					cur_q   <= NODE_W'(nf_q);
					nf_q    <= nf_q + 1'b1;
					depth_q <= depth_q + 1'b1;
					if (depth_q + 1'b1 == len_q) begin
						state_q <= S_CISS;
					end
				end
				S_CISS: begin
					state_q <= S_CRD;
				end
				S_CRD: begin
					result_q.prefix_found <= 1'b1;
					result_q.status       <= ST_OK;
					result_q.word_count   <= act_q ? cn_rdata : cn_req.wdata;
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			// clear the per-word state with each result
			if ((state_q == S_CRD) || ((state_q == S_FIN) && (act_q ? miss_q :
				((len_q == '0) || bad_q || (len_q > LEN_W'(MAX_WORD_LEN)) ||
				(nf_q > NF_W'(NODE_POOL)) || ((NF_W+1)'(needed) > room))))) begin
				cur_q   <= '0;
				len_q   <= '0;
				depth_q <= '0;
				bad_q   <= 1'b0;
				miss_q  <= 1'b0;
			end
		end
	end

	// checks
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (state_q == S_IDLE))
		else $error("result strobe outside idle");
	a_found_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && result_q.prefix_found) |-> (result_q.status == ST_OK))
		else $error("found with failing status");
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && (result_q.status != ST_OK)) |-> (result_q.word_count == '0))
		else $error("count on a failed insert");
	a_pool: assert property (@(posedge clk) disable iff (!arst_n)
		nf_q <= NF_W'(NODE_POOL))
		else $error("node pool overrun");
	a_clear_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> (!done_q && (state_q == S_IDLE)))
		else $error("activity during clearing pass");

endmodule

@@ tb/prefix_trie_engine_test.sv @@
// ----------------------------------------------------------------------------
// prefix_trie_engine_test
// Self-checking bench for the prefix tree engine: words and prefixes are fed
// one character per transaction and every closing result is checked against
// a behavioural trie kept in the bench.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module prefix_trie_engine_test;
	import pte_pkg::*;

	localparam int CYCLE_LIMIT = 2000000;

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    start = 1'b0;
	logic    busy;
	item_t   item = '0;
	logic    done;
	result_t result;

	prefix_trie_engine u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.item(item), .done(done), .result(result)
	);

	always #4 clk = ~clk;

	// trie mirror
	int unsigned kids[NODE_POOL][BRANCHES];
	int unsigned counts[NODE_POOL];
	int unsigned free_node;
	int unsigned walk_node;
	int unsigned letters[MAX_WORD_LEN];
	int unsigned seen_len;
	bit          bad_seen;
	bit          off_tree;

	result_t     pending_results[$];
	int          fail_count = 0;
	int          result_count = 0;
	int          item_count = 0;
	int          cycle_count = 0;
	bit          quiet_sender = 1'b0;
	string       word_pool[$];

	function automatic void clear_walk();
		walk_node = 0;
		seen_len = 0;
		bad_seen = 1'b0;
		off_tree = 1'b0;
	endfunction

	function automatic void take_letter(logic [7:0] code);
		bit ok;
		int unsigned ltr;
		ok = (code >= LETTER_LO) && (code <= LETTER_HI);
		ltr = ok ? code - LETTER_LO : 0;
		if (seen_len < MAX_WORD_LEN && ok) letters[seen_len] = ltr;
		if (seen_len <= MAX_WORD_LEN) seen_len++;
		if (!ok) begin
			bad_seen = 1'b1;
			off_tree = 1'b1;
		end else if (!off_tree) begin
			if (kids[walk_node][ltr] == 0) off_tree = 1'b1;
			else walk_node = kids[walk_node][ltr];
		end
	endfunction

	function automatic logic [1:0] add_word(output int unsigned cnt);
		int unsigned nd, dep, need;
		nd = 0;
		dep = 0;
		cnt = 0;
		if (seen_len == 0 || bad_seen) return ST_IGNORED;
		if (seen_len > MAX_WORD_LEN) return ST_LONG;
		while (dep < seen_len && kids[nd][letters[dep]] != 0) begin
			nd = kids[nd][letters[dep]];
			dep++;
		end
		need = seen_len - dep;
		if (free_node > NODE_POOL || need > NODE_POOL - free_node) return ST_FULL;
		for (int i = dep; i < seen_len; i++) begin
			kids[nd][letters[i]] = free_node;
			nd = free_node;
			free_node++;
		end
		if (counts[nd] < 16'hffff) counts[nd]++;
		cnt = counts[nd];
		return ST_OK;
	endfunction

	// predicted outcome of one transaction
	function automatic void predict_item(item_t it);
		result_t r;
		int unsigned cnt;
		if (!it.no_char) take_letter(it.char_code);
		if (!it.last) return;
		r = '0;
		if (it.action == 1'b0) begin
			r.status = add_word(cnt);
			r.prefix_found = (r.status == ST_OK);
			r.word_count = CNT_W'(cnt);
		end else if (!off_tree) begin
			r.prefix_found = 1'b1;
			r.word_count = CNT_W'(counts[walk_node]);
		end
		pending_results.push_back(r);
		clear_walk();
	endfunction

	// one transaction, with random idling before it unless quiet_sender is set
	task automatic send_item(logic act, logic [7:0] code, logic nc, logic lst);
		item_t it;
		it = '{action: act, char_code: code, no_char: nc, last: lst};
		while (!quiet_sender && $urandom_range(99) < 27) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		item <= it;
		@(posedge clk);
		while (busy) @(posedge clk);
		predict_item(it);
		item_count++;
	endtask

	task automatic send_word(logic act, string s);
		if (s.len() == 0) begin
			send_item(act, 8'h00, 1'b1, 1'b1);
			return;
		end
		for (int i = 0; i < s.len(); i++)
			send_item(act, s[i], 1'b0, i == s.len() - 1);
	endtask

	function automatic string rand_word(int unsigned maxlen);
		string s;
		int unsigned n;
		s = "";
		n = $urandom_range(maxlen, 1);
		for (int i = 0; i < n; i++)
			s = {s, string'(byte'(8'h61 + $urandom_range(3)))};
		return s;
	endfunction

	task automatic wait_drained();
		start <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	// result checker
	always @(posedge clk) begin
		result_t want;
		if (done) begin
			result_count++;
			if (pending_results.size() == 0) begin
				$error("unexpected result transaction");
				fail_count++;
			end else begin
				want = pending_results.pop_front();
				if (result.word_count !== want.word_count) begin
					$error("word_count expected %0d actual %0d", want.word_count,
						result.word_count);
					fail_count++;
				end
				if (result.prefix_found !== want.prefix_found) begin
					$error("prefix_found expected %0d actual %0d", want.prefix_found,
						result.prefix_found);
					fail_count++;
				end
				if (result.status !== want.status) begin
					$error("status expected %0d actual %0d", want.status, result.status);
					fail_count++;
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	task automatic test_special_cases();
		string longw;
		send_word(1'b1, "");
		send_word(1'b0, "");
		send_word(1'b0, "az");
		send_word(1'b0, "az");
		send_word(1'b1, "az");
		send_word(1'b1, "a");
		send_word(1'b1, "zz");
		send_item(1'b0, 8'h41, 1'b0, 1'b0);
		send_item(1'b0, 8'hff, 1'b0, 1'b1);
		send_item(1'b1, 8'h00, 1'b0, 1'b1);
		// mixed actions, closing no-char item
		send_item(1'b1, "q", 1'b0, 1'b0);
		send_item(1'b0, 8'h7b, 1'b1, 1'b1);
		send_item(1'b1, "q", 1'b0, 1'b0);
		send_item(1'b1, 8'h00, 1'b1, 1'b1);
		longw = "";
		for (int i = 0; i < MAX_WORD_LEN + 1; i++) longw = {longw, "m"};
		send_word(1'b0, longw);
		send_word(1'b0, longw.substr(0, MAX_WORD_LEN - 1));
		send_word(1'b1, longw);
		wait_drained();
	endtask

	task automatic test_random_traffic();
		string w;
		int unsigned pick;
		for (int n = 0; n < 80; n++) begin
			quiet_sender = (n >= 40 && n < 60);
			pick = $urandom_range(99);
			if (pick < 40 || word_pool.size() == 0) begin
				w = rand_word(8);
				word_pool.push_back(w);
				send_word(1'b0, w);
			end else if (pick < 80) begin
				w = word_pool[$urandom_range(word_pool.size() - 1)];
				if ($urandom_range(1)) w = w.substr(0, $urandom_range(w.len() - 1));
				send_word(1'b1, w);
			end else begin
				// noise: raw bytes, random marks
				repeat ($urandom_range(4, 1))
					send_item(1'($urandom_range(1)), 8'($urandom_range(255)),
						1'($urandom_range(1)), 1'b0);
				send_item(1'($urandom_range(1)), 8'($urandom_range(255)),
					1'($urandom_range(1)), 1'b1);
			end
			if (n == 70) wait_drained();
		end
		quiet_sender = 1'b0;
		wait_drained();
	endtask

	task automatic test_long_words();
		// random words of up to MAX_WORD_LEN letters to deepen the tree
		for (int n = 0; n < 4; n++) send_word(1'b0, rand_word(MAX_WORD_LEN));
		send_word(1'b0, "zzzzzzzz");
		send_word(1'b1, "a");
		wait_drained();
	endtask

	initial begin
		free_node = 1;
		foreach (counts[i]) counts[i] = 0;
		foreach (kids[i, j]) kids[i][j] = 0;
		foreach (letters[i]) letters[i] = 0;
		clear_walk();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_special_cases();
		test_random_traffic();
		test_long_words();
		$display("Sent %0d transactions, checked %0d results, %0d of %0d nodes used.",
			item_count, result_count, free_node, NODE_POOL);
		if (fail_count == 0 && pending_results.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
